### rtl/core/ltks_pkg.sv
// Package for the light top-k score selector: sizes, constants and shared types.
// Used by every module under rtl/core; depends on nothing.
package ltks_pkg;

  // Table size and derived widths.
  localparam int MaxLights = 8;
  localparam int SlotW     = (MaxLights > 1) ? $clog2(MaxLights) : 1;
  localparam int CntW      = $clog2(MaxLights + 1);
  localparam int OutSlotW  = 3;
  localparam int OutCntW   = 4;

  // Fixed-point widths of the score datapath.
  localparam int PosW  = 24;
  localparam int DiffW = PosW + 1;
  localparam int SqW   = 2 * PosW + 1;
  localparam int DenW  = SqW + 1;
  localparam int NumW  = 51;
  localparam int ScoreW = 32;
  localparam int DivCntW = $clog2(NumW);

  // Filter and weight constants; OneQ16 is Q34.16, WNotImportant is Q0.8.
  localparam logic [15:0] RangeMin   = 16'd12;
  localparam logic [DenW-1:0] OneQ16 = DenW'(65536);
  localparam logic [6:0] WNotImportant = 7'd90;

  // Render mode codes.
  localparam logic [1:0] ModeAuto         = 2'd0;
  localparam logic [1:0] ModeImportant    = 2'd1;
  localparam logic [1:0] ModeNotImportant = 2'd2;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CfgCameraMask = 2'd0,
    CfgEyeX       = 2'd1,
    CfgEyeY       = 2'd2,
    CfgEyeZ       = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0]     camera_mask;
    logic [PosW-1:0] eye_x;
    logic [PosW-1:0] eye_y;
    logic [PosW-1:0] eye_z;
  } cfg_t;

  // One classified light on its way from the front to the back.
  typedef struct packed {
    logic            start_frame;
    logic            pass;
    logic [15:0]     light_id;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } job_t;

endpackage

### rtl/core/ltks_front.sv
// Front part of the light selector: accepts a light, applies the filters and
// forms the score numerator and denominator. Depends on ltks_pkg.
module ltks_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ltks_pkg::cfg_t  cfg_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            start_frame_i,
  input  logic [15:0]     light_id_i,
  input  logic            active_i,
  input  logic            baked_i,
  input  logic [31:0]     light_mask_i,
  input  logic [15:0]     intensity_i,
  input  logic [15:0]     light_range_i,
  input  logic [1:0]      render_mode_i,
  input  logic [23:0]     pos_x_i,
  input  logic [23:0]     pos_y_i,
  input  logic [23:0]     pos_z_i,
  output logic            push_o,
  output ltks_pkg::job_t  job_o,
  input  logic            full_i
);
  import ltks_pkg::*;

  typedef enum logic [1:0] {
    FIdle,
    FMul1,
    FMul2,
    FPush
  } state_e;

  state_e state_q, state_d;

  logic            start_q;
  logic            pass_q;
  logic [15:0]     id_q;
  logic [15:0]     inten_q;
  logic [15:0]     range_q;
  logic [1:0]      mode_q;
  logic [PosW-1:0] px_q, py_q, pz_q;
  logic [SqW-1:0]  sqx_q, sqy_q, sqz_q;
  logic [31:0]     p1_q;
  logic [47:0]     p2_q;
  logic [DenW-1:0] den_q;

  logic               pass_d;
  logic signed [DiffW-1:0] dx, dy, dz;
  logic signed [2*DiffW-1:0] sx, sy, sz;
  logic [54:0]        p2_w90;
  logic [NumW-1:0]    num;

  // Filter checks on the incoming beat.
  assign pass_d = active_i && !baked_i && ((light_mask_i & cfg_i.camera_mask) != 32'd0)
               && (intensity_i != 16'd0) && (light_range_i > RangeMin);

  // Per-axis distance to the eye, squared.
  assign dx = $signed({px_q[PosW-1], px_q}) - $signed({cfg_i.eye_x[PosW-1], cfg_i.eye_x});
  assign dy = $signed({py_q[PosW-1], py_q}) - $signed({cfg_i.eye_y[PosW-1], cfg_i.eye_y});
  assign dz = $signed({pz_q[PosW-1], pz_q}) - $signed({cfg_i.eye_z[PosW-1], cfg_i.eye_z});
  assign sx = (2*DiffW)'(dx) * (2*DiffW)'(dx);
  assign sy = (2*DiffW)'(dy) * (2*DiffW)'(dy);
  assign sz = (2*DiffW)'(dz) * (2*DiffW)'(dz);

  // Weighted numerator, already shifted right by eight.
  assign p2_w90 = 55'(p2_q) * 55'(WNotImportant);
  always_comb begin
    case (mode_q)
      ModeImportant:    num = NumW'({p2_q, 2'b00});
      ModeNotImportant: num = NumW'(p2_w90 >> 8);
      default:          num = NumW'(p2_q);
    endcase
  end

  assign in_ready_o = (state_q == FIdle);
  assign push_o     = (state_q == FPush) && !full_i;

  assign job_o.start_frame = start_q;
  assign job_o.pass        = pass_q;
  assign job_o.light_id    = id_q;
  assign job_o.num         = num;
  assign job_o.den         = den_q;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      FIdle:   if (in_valid_i) state_d = FMul1;
      FMul1:   state_d = FMul2;
      FMul2:   state_d = FPush;
      FPush:   if (!full_i) state_d = FIdle;
      default: state_d = FIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      FIdle: begin
        if (in_valid_i) begin
          start_q <= start_frame_i;
          pass_q  <= pass_d;
          id_q    <= light_id_i;
          inten_q <= intensity_i;
          range_q <= light_range_i;
          mode_q  <= render_mode_i;
          px_q    <= pos_x_i;
          py_q    <= pos_y_i;
          pz_q    <= pos_z_i;
        end
      end
      FMul1: begin
        sqx_q <= SqW'(sx);
        sqy_q <= SqW'(sy);
        sqz_q <= SqW'(sz);
        p1_q  <= 32'(inten_q) * 32'(range_q);
      end
      FMul2: begin
        den_q <= OneQ16 + DenW'(sqx_q) + DenW'(sqy_q) + DenW'(sqz_q);
        p2_q  <= 48'(p1_q) * 48'(range_q);
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/core/ltks_queue.sv
// Two-entry queue between the front and back of the light selector.
// Depends on ltks_pkg for the job type.
module ltks_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ltks_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output ltks_pkg::job_t job_o
);
  import ltks_pkg::*;

  job_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign job_o   = mem_q[rd_ptr_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= job_i;
  end

endmodule

### rtl/core/ltks_back.sv
// Back part of the light selector: divides, scans a full slot table for the
// weakest light, updates the table and holds the result. Depends on ltks_pkg.
module ltks_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  ltks_pkg::job_t  job_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            accepted_o,
  output logic [2:0]      slot_o,
  output logic            evicted_valid_o,
  output logic [15:0]     evicted_id_o,
  output logic [31:0]     light_score_o,
  output logic [3:0]      light_count_o
);
  import ltks_pkg::*;

  typedef enum logic [2:0] {
    BIdle,
    BDiv,
    BEval,
    BScan,
    BDone
  } state_e;

  state_e state_q;

  logic [CntW-1:0]    count_q;
  logic [NumW-1:0]    num_q;
  logic [DenW-1:0]    den_q;
  logic [DenW-1:0]    rem_q;
  logic [NumW-1:0]    quo_q;
  logic [DivCntW-1:0] bit_q;
  logic [15:0]        id_q;
  logic [ScoreW-1:0]  score_q;
  logic [ScoreW-1:0]  worst_q;
  logic [SlotW-1:0]   idx_q;
  logic [SlotW-1:0]   target_q;
  logic               found_q;
  logic               evict_q;

  logic [ScoreW-1:0] slot_scores_q [MaxLights];
  logic [15:0]       slot_ids_q [MaxLights];

  logic [DenW:0]     rem_sh;
  logic              qbit;
  logic [DenW:0]     rem_sub;
  logic [ScoreW-1:0] score_sat;
  logic              full;
  logic              done_fire;

  // One quotient bit per cycle, restoring.
  assign rem_sh  = {rem_q, num_q[NumW-1]};
  assign qbit    = (rem_sh >= {1'b0, den_q});
  assign rem_sub = rem_sh - {1'b0, den_q};

  assign score_sat = (|quo_q[NumW-1:ScoreW]) ? '1 : quo_q[ScoreW-1:0];
  assign full      = (count_q == CntW'(MaxLights));
  assign pop_o     = (state_q == BIdle) && !empty_i;
  assign done_fire = (state_q == BDone) && (!out_valid_o || out_ready_i);

  // Sequencer, fill count and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= BIdle;
      count_q         <= '0;
      out_valid_o     <= 1'b0;
      accepted_o      <= 1'b0;
      slot_o          <= '0;
      evicted_valid_o <= 1'b0;
      evicted_id_o    <= '0;
      light_score_o   <= '0;
      light_count_o   <= '0;
    end else begin
      // The result beat stays until taken; a new one replaces it on the same edge.
      if (done_fire) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
      case (state_q)
        BIdle: begin
          if (!empty_i) begin
            if (job_i.start_frame) count_q <= '0;
            state_q <= job_i.pass ? BDiv : BDone;
          end
        end
        BDiv: begin
          if (bit_q == DivCntW'(NumW - 1)) state_q <= BEval;
        end
        BEval: begin
          if (score_sat == '0 || !full) state_q <= BDone;
          else state_q <= BScan;
        end
        BScan: begin
          if (idx_q == SlotW'(MaxLights - 1)) state_q <= BDone;
        end
        BDone: begin
          if (done_fire) begin
            accepted_o      <= found_q;
            slot_o          <= found_q ? OutSlotW'(target_q) : '0;
            evicted_valid_o <= evict_q;
            evicted_id_o    <= evict_q ? slot_ids_q[target_q] : 16'd0;
            light_score_o   <= score_q;
            if (found_q && !evict_q) begin
              count_q       <= count_q + CntW'(1);
              light_count_o <= OutCntW'(count_q + CntW'(1));
            end else begin
              light_count_o <= OutCntW'(count_q);
            end
            state_q <= BIdle;
          end
        end
        default: state_q <= BIdle;
      endcase
    end
  end

  // Divider, scan and table datapath.
  always_ff @(posedge clk_i) begin
    case (state_q)
      BIdle: begin
        num_q   <= job_i.num;
        den_q   <= job_i.den;
        id_q    <= job_i.light_id;
        rem_q   <= '0;
        quo_q   <= '0;
        bit_q   <= '0;
        score_q <= '0;
        found_q <= 1'b0;
        evict_q <= 1'b0;
      end
      BDiv: begin
        rem_q <= qbit ? DenW'(rem_sub) : DenW'(rem_sh);
        quo_q <= {quo_q[NumW-2:0], qbit};
        num_q <= {num_q[NumW-2:0], 1'b0};
        bit_q <= bit_q + DivCntW'(1);
      end
      BEval: begin
        score_q  <= score_sat;
        worst_q  <= score_sat;
        idx_q    <= '0;
        target_q <= SlotW'(count_q);
        found_q  <= (score_sat != '0) && !full;
      end
      BScan: begin
        if (slot_scores_q[idx_q] < worst_q) begin
          worst_q  <= slot_scores_q[idx_q];
          target_q <= idx_q;
          found_q  <= 1'b1;
          evict_q  <= 1'b1;
        end
        idx_q <= idx_q + SlotW'(1);
      end
      BDone: begin
        if (done_fire && found_q) begin
          slot_scores_q[target_q] <= score_q;
          slot_ids_q[target_q]    <= id_q;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/core/light_top_k_score_select_unit.sv
// Top level of the light top-k score selector: configuration registers and
// the front, queue and back parts. Depends on ltks_pkg and the ltks_* modules.
//
//   Channel   Signals                              Direction
//   cfg       cfg_we_i, cfg_idx_i, cfg_wdata_i     write only
//   in        in_valid_i / in_ready_o + fields     one light per beat
//   out       out_valid_o / out_ready_i + fields   one result per beat
//
// The front takes a light in FIdle, then runs FMul1, FMul2 and FPush; FPush
// waits while the queue is full. The back skips division for a filtered light,
// divides a scored one in 51 steps and scans 8 slots once all are full.
// Reset clears the fill count and restores the configuration defaults.
// A stalled output holds the back; the two-beat queue lets the front go on.
module light_top_k_score_select_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        start_frame_i,
  input  logic [15:0] light_id_i,
  input  logic        active_i,
  input  logic        baked_i,
  input  logic [31:0] light_mask_i,
  input  logic [15:0] intensity_i,
  input  logic [15:0] light_range_i,
  input  logic [1:0]  render_mode_i,
  input  logic [23:0] pos_x_i,
  input  logic [23:0] pos_y_i,
  input  logic [23:0] pos_z_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        accepted_o,
  output logic [2:0]  slot_o,
  output logic        evicted_valid_o,
  output logic [15:0] evicted_id_o,
  output logic [31:0] light_score_o,
  output logic [3:0]  light_count_o
);
  import ltks_pkg::*;

  cfg_t cfg_q;
  job_t job_in, job_out;
  logic push, full, pop, empty;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.camera_mask <= '1;
      cfg_q.eye_x       <= '0;
      cfg_q.eye_y       <= '0;
      cfg_q.eye_z       <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgCameraMask: cfg_q.camera_mask <= cfg_wdata_i;
        CfgEyeX:       cfg_q.eye_x       <= cfg_wdata_i[PosW-1:0];
        CfgEyeY:       cfg_q.eye_y       <= cfg_wdata_i[PosW-1:0];
        CfgEyeZ:       cfg_q.eye_z       <= cfg_wdata_i[PosW-1:0];
        default:       cfg_q             <= cfg_q;
      endcase
    end
  end

  ltks_front u_front (
    .clk_i, .rst_ni,
    .cfg_i        (cfg_q),
    .in_valid_i, .in_ready_o,
    .start_frame_i, .light_id_i, .active_i, .baked_i, .light_mask_i,
    .intensity_i, .light_range_i, .render_mode_i,
    .pos_x_i, .pos_y_i, .pos_z_i,
    .push_o       (push),
    .job_o        (job_in),
    .full_i       (full)
  );

  ltks_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .job_o   (job_out)
  );

  ltks_back u_back (
    .clk_i, .rst_ni,
    .empty_i (empty),
    .job_i   (job_out),
    .pop_o   (pop),
    .out_valid_o, .out_ready_i,
    .accepted_o, .slot_o, .evicted_valid_o, .evicted_id_o,
    .light_score_o, .light_count_o
  );

endmodule

### sim/tb_top.sv
// Self-checking testbench for light_top_k_score_select_unit.
// It runs a directed table and then random phases, and checks every result beat
// against the top-k model or hand-read values. It depends on ltks_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
  import ltks_pkg::*;

  // One offered light and one result of the block.
  typedef struct {
    logic        start;
    logic [15:0] id;
    logic        act;
    logic        bkd;
    logic [31:0] mask;
    logic [15:0] inten;
    logic [15:0] rng;
    logic [1:0]  mode;
    logic [23:0] px;
    logic [23:0] py;
    logic [23:0] pz;
  } light_t;

  typedef struct {
    logic        acc;
    logic [2:0]  slot;
    logic        ev;
    logic [15:0] ev_id;
    logic [31:0] score;
    logic [3:0]  cnt;
  } verdict_t;

  // A row of the directed table; typed rows carry hand-read results.
  typedef struct {
    light_t      l;
    bit          typed;
    logic        acc;
    logic [31:0] score;
    logic [3:0]  cnt;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        start_frame_i = 1'b0;
  logic [15:0] light_id_i = '0;
  logic        active_i = 1'b0;
  logic        baked_i = 1'b0;
  logic [31:0] light_mask_i = '0;
  logic [15:0] intensity_i = '0;
  logic [15:0] light_range_i = '0;
  logic [1:0]  render_mode_i = '0;
  logic [23:0] pos_x_i = '0;
  logic [23:0] pos_y_i = '0;
  logic [23:0] pos_z_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        accepted_o;
  logic [2:0]  slot_o;
  logic        evicted_valid_o;
  logic [15:0] evicted_id_o;
  logic [31:0] light_score_o;
  logic [3:0]  light_count_o;

  light_top_k_score_select_unit u_top (.*);

  // Model state: configuration copy and the slot table.
  logic [31:0] cam_mask = '1;
  logic [23:0] eye_x = '0;
  logic [23:0] eye_y = '0;
  logic [23:0] eye_z = '0;
  logic [31:0] tbl_score [MaxLights];
  logic [15:0] tbl_id [MaxLights];
  int          tbl_fill = 0;

  verdict_t pending_results[$];
  int       errors = 0;
  bit       hold_go = 1'b0;
  row_t     dir_rows[$];

  // Clock with a 2 ns period.
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Hard limit on the run.
  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic longint unsigned axis_sq(logic [23:0] p, logic [23:0] e);
    longint d;
    d = longint'($signed(p)) - longint'($signed(e));
    return longint'(d * d);
  endfunction

  // Scores one light and updates the slot table as the block does.
  function automatic verdict_t score_and_place(light_t l);
    verdict_t         v;
    longint unsigned  w, a, num, den, q;
    logic [31:0]      worst;
    int               target;
    v = '{default: '0};
    if (l.start) tbl_fill = 0;
    if (l.act && !l.bkd && ((l.mask & cam_mask) != 0) && l.inten != 0 && l.rng > 12) begin
      w = 256;
      if (l.mode == ModeImportant) w = 1024;
      else if (l.mode == ModeNotImportant) w = 90;
      a = 64'(l.inten);
      num = (a * 64'(l.rng) * 64'(l.rng) * w) >> 8;
      den = 65536 + axis_sq(l.px, eye_x) + axis_sq(l.py, eye_y) + axis_sq(l.pz, eye_z);
      q = num / den;
      v.score = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
      if (v.score != 0) begin
        target = MaxLights;
        worst = v.score;
        if (tbl_fill < MaxLights) begin
          target = tbl_fill;
        end else begin
          for (int i = 0; i < MaxLights; i++) begin
            if (tbl_score[i] < worst) begin
              worst = tbl_score[i];
              target = i;
            end
          end
          if (target < MaxLights) begin
            v.ev = 1'b1;
            v.ev_id = tbl_id[target];
          end
        end
        if (target < MaxLights) begin
          tbl_score[target] = v.score;
          tbl_id[target] = l.id;
          if (tbl_fill < MaxLights) tbl_fill++;
          v.acc = 1'b1;
          v.slot = target[2:0];
        end
      end
    end
    v.cnt = tbl_fill[3:0];
    return v;
  endfunction

  function automatic light_t mk(logic s, logic [15:0] id, logic act, logic bkd,
                                logic [31:0] m, logic [15:0] i, logic [15:0] r,
                                logic [1:0] md, logic [23:0] x, logic [23:0] y,
                                logic [23:0] z);
    light_t l;
    l = '{s, id, act, bkd, m, i, r, md, x, y, z};
    return l;
  endfunction

  // Random light: mostly valid lights near the eye, some pure noise.
  function automatic light_t rand_light();
    light_t l;
    int     sel;
    l.start = ($urandom_range(0, 39) == 0);
    l.id = 16'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 15) begin
      l.act = 1'($urandom); l.bkd = 1'($urandom); l.mask = $urandom;
      l.inten = 16'($urandom); l.rng = 16'($urandom); l.mode = 2'($urandom);
      l.px = 24'($urandom); l.py = 24'($urandom); l.pz = 24'($urandom);
    end else begin
      l.act = 1'b1;
      l.bkd = ($urandom_range(0, 19) == 0);
      l.mask = $urandom_range(0, 3) == 0 ? $urandom : 32'hFFFF_FFFF;
      l.inten = $urandom_range(0, 2) == 0 ? 16'(256 << $urandom_range(0, 7)) : 16'($urandom);
      l.rng = 16'($urandom_range(13, 3000));
      l.mode = 2'($urandom);
      l.px = eye_x + 24'($signed($urandom_range(0, 8191)) - 4096);
      l.py = eye_y + 24'($signed($urandom_range(0, 8191)) - 4096);
      l.pz = eye_z + 24'($signed($urandom_range(0, 8191)) - 4096);
      if (sel > 92) l.px = 24'($urandom);
    end
    return l;
  endfunction

  task automatic cfg_write(cfg_idx_e idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgCameraMask: cam_mask = val;
      CfgEyeX: eye_x = val[23:0];
      CfgEyeY: eye_y = val[23:0];
      default: eye_z = val[23:0];
    endcase
  endtask

  // Waits until every result beat has arrived, then lets the back settle.
  task automatic drain();
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  // Offers one beat from a falling edge; returns at the falling edge after acceptance.
  task automatic send(light_t l, bit typed, logic acc, logic [31:0] sc, logic [3:0] cnt);
    verdict_t v;
    in_valid_i <= 1'b1;
    start_frame_i <= l.start; light_id_i <= l.id; active_i <= l.act; baked_i <= l.bkd;
    light_mask_i <= l.mask; intensity_i <= l.inten; light_range_i <= l.rng;
    render_mode_i <= l.mode; pos_x_i <= l.px; pos_y_i <= l.py; pos_z_i <= l.pz;
    do @(posedge clk_i); while (!in_ready_o);
    v = score_and_place(l);
    if (typed) begin
      v.acc = acc; v.score = sc; v.cnt = cnt;
    end
    pending_results.push_back(v);
    @(negedge clk_i);
  endtask

  // Sender burst control between beats.
  int burst_left = 1;
  task automatic maybe_gap();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid_i <= 1'b0;
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20);
      repeat (gap) @(negedge clk_i);
      burst_left = $urandom_range(1, 30);
    end
  endtask

  // Main stimulus.
  initial begin
    light_t l;
    logic [31:0] masks [4];
    logic [23:0] eyes [4];
    int n_items;
    masks = '{32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 32'h0000_0000};
    eyes = '{24'h000000, 24'h7FFFFF, 24'h800000, 24'h001234};
    // Directed table: rejections, extremes, fill, eviction and ties.
    dir_rows.push_back('{mk(1, 1, 0, 0, '1, 256, 256, ModeAuto, 0, 0, 0), 1, 0, 0, 0});
    dir_rows.push_back('{mk(0, 2, 1, 1, '1, 256, 256, ModeAuto, 0, 0, 0), 1, 0, 0, 0});
    dir_rows.push_back('{mk(0, 3, 1, 0, 0, 256, 256, ModeAuto, 0, 0, 0), 1, 0, 0, 0});
    dir_rows.push_back('{mk(0, 4, 1, 0, '1, 0, 256, ModeAuto, 0, 0, 0), 1, 0, 0, 0});
    dir_rows.push_back('{mk(0, 5, 1, 0, '1, 256, 12, ModeAuto, 0, 0, 0), 1, 0, 0, 0});
    dir_rows.push_back('{mk(0, 6, 1, 0, '1, 1, 13, ModeAuto, 0, 0, 0), 1, 0, 0, 0});
    dir_rows.push_back('{mk(0, 7, 1, 0, '1, 256, 256, ModeAuto, 0, 0, 0), 1, 1, 256, 1});
    dir_rows.push_back('{mk(0, 8, 1, 0, '1, '1, '1, ModeImportant, 0, 0, 0), 1, 1, '1, 2});
    dir_rows.push_back('{mk(0, 9, 1, 0, '1, '1, '1, ModeNotImportant,
                            24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF), 0, 0, 0, 0});
    dir_rows.push_back('{mk(0, 10, 1, 0, '1, '1, '1, 2'd3,
                            24'h800000, 24'h800000, 24'h800000), 0, 0, 0, 0});
    for (int i = 0; i < 6; i++)
      dir_rows.push_back('{mk(0, 16'(11 + i), 1, 0, '1, 256, 256, ModeAuto, 0, 0, 0),
                           0, 0, 0, 0});
    dir_rows.push_back('{mk(0, 20, 1, 0, '1, 512, 256, ModeAuto, 0, 0, 0), 0, 0, 0, 0});
    dir_rows.push_back('{mk(0, 21, 1, 0, '1, 256, 256, ModeAuto, 0, 0, 0), 0, 0, 0, 0});
    dir_rows.push_back('{mk(0, 22, 1, 0, '1, 1, 256, ModeAuto, 0, 0, 0), 0, 0, 0, 0});
    dir_rows.push_back('{mk(0, 23, 1, 0, '1, '1, '1, ModeImportant, 0, 0, 0), 0, 0, 0, 0});
    dir_rows.push_back('{mk(1, 24, 0, 1, 0, 0, 0, ModeAuto, 0, 0, 0), 1, 0, 0, 0});
    dir_rows.push_back('{mk(0, 16'hFFFF, 1, 0, '1, 300, 900, ModeImportant,
                            24'h000100, 24'hFFFF00, 24'h000000), 0, 0, 0, 0});

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(negedge clk_i);

    foreach (dir_rows[i]) begin
      send(dir_rows[i].l, dir_rows[i].typed, dir_rows[i].acc, dir_rows[i].score,
           dir_rows[i].cnt);
      maybe_gap();
    end
    in_valid_i <= 1'b0;
    drain();

    // Random phases, each under a new configuration written while idle.
    for (int ph = 0; ph < 6; ph++) begin
      if (ph < 4) begin
        cfg_write(CfgCameraMask, masks[ph]);
        cfg_write(CfgEyeX, {8'h00, eyes[ph]});
        cfg_write(CfgEyeY, {8'h00, eyes[(ph + 1) % 4]});
        cfg_write(CfgEyeZ, {8'h00, eyes[(ph + 2) % 4]});
      end else begin
        cfg_write(CfgCameraMask, $urandom);
        cfg_write(CfgEyeX, {8'h00, 24'($urandom)});
        cfg_write(CfgEyeY, {8'h00, 24'($urandom)});
        cfg_write(CfgEyeZ, {8'h00, 24'($urandom)});
      end
      n_items = (ph == 3) ? 100 : 280;
      for (int k = 0; k < n_items; k++) begin
        if (ph == 1 && k == 40) hold_go = 1'b1;
        l = rand_light();
        send(l, 0, 0, 0, 0);
        maybe_gap();
      end
      in_valid_i <= 1'b0;
      drain();
    end

    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Receiver: ready follows a randomly picked pattern; one long hold-off on request.
  initial begin
    int pat;
    int cyc;
    pat = 0;
    cyc = 0;
    forever begin
      @(negedge clk_i);
      if (hold_go) begin
        hold_go = 1'b0;
        out_ready_i <= 1'b0;
        repeat (400) @(negedge clk_i);
      end
      cyc++;
      if (cyc % 64 == 0) pat = $urandom_range(0, 2);
      case (pat)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= 1'($urandom);
        default: out_ready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Result monitor: each beat against the oldest expectation.
  always @(posedge clk_i) begin
    verdict_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report("unexpected beat", light_score_o, 0);
      end else begin
        e = pending_results.pop_front();
        if (accepted_o !== e.acc) report("accepted", accepted_o, e.acc);
        if (slot_o !== e.slot) report("slot", slot_o, e.slot);
        if (evicted_valid_o !== e.ev) report("evicted_valid", evicted_valid_o, e.ev);
        if (evicted_id_o !== e.ev_id) report("evicted_id", evicted_id_o, e.ev_id);
        if (light_score_o !== e.score) report("light_score", light_score_o, e.score);
        if (light_count_o !== e.cnt) report("light_count", light_count_o, e.cnt);
      end
    end
  end

endmodule

### sim.f
rtl/core/ltks_pkg.sv
rtl/core/ltks_front.sv
rtl/core/ltks_queue.sv
rtl/core/ltks_back.sv
rtl/core/light_top_k_score_select_unit.sv
sim/tb_top.sv
